### hdl/dfw_pkg.sv
// ----------------------------------------------------------------------------
// dfw_pkg
// Shared types, step codes and the control store of the depth-first walk
// engine.
// ----------------------------------------------------------------------------
package dfw_pkg;

    localparam int NODE_W = 6;
    localparam int STEP_W = 4;

    typedef logic [NODE_W-1:0] t_node;
    typedef logic [STEP_W-1:0] t_step;

    // command word and result word
    typedef struct packed {
        logic  func;
        t_node node_a;
        t_node node_b;
    } t_cmd;

    typedef struct packed {
        t_node node;
        logic  last;
    } t_res;

    localparam logic FUNC_EDGE = 1'b0;
    localparam logic FUNC_WALK = 1'b1;

    localparam t_node NODE_COUNT_RST = 6'd32;

    // step addresses of the control store
    localparam t_step S_IDLE      = 4'd0;
    localparam t_step S_DISPATCH  = 4'd1;
    localparam t_step S_EDGE_RD   = 4'd2;
    localparam t_step S_EDGE_WA   = 4'd3;
    localparam t_step S_EDGE_WB   = 4'd4;
    localparam t_step S_WALK_INIT = 4'd5;
    localparam t_step S_WALK_ROOT = 4'd6;
    localparam t_step S_ROW_RD    = 4'd7;
    localparam t_step S_DECIDE    = 4'd8;
    localparam t_step S_POP       = 4'd9;
    localparam t_step S_CHECK     = 4'd10;
    localparam t_step S_ZERO      = 4'd11;
    localparam t_step S_FLUSH     = 4'd12;

    // datapath actions
    typedef enum logic [3:0] {
        A_NOP,
        A_EDGE_RD_A,
        A_EDGE_WR_A,
        A_EDGE_WR_B,
        A_INIT,
        A_PUSH_ROOT,
        A_RD_TOP,
        A_STEP,
        A_POP,
        A_ZERO,
        A_FLUSH
    } t_act;

    // jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOSTART,
        C_WALK,
        C_EDGE_BAD,
        C_START_BAD,
        C_CAND,
        C_DEPTH_NZ,
        C_ALL_LIT
    } t_cond;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_step target;
    } t_uword;

    // datapath flags seen by the sequencer
    typedef struct packed {
        logic walk;
        logic edge_bad;
        logic start_bad;
        logic cand;
        logic depth_nz;
        logic all_lit;
    } t_stat;

    // control store: one word per step
    function automatic t_uword ucode(input t_step pc);
        t_uword w;
        case (pc)
            S_IDLE:      w = '{A_NOP,       C_NOSTART,   S_IDLE};
            S_DISPATCH:  w = '{A_NOP,       C_WALK,      S_WALK_INIT};
            S_EDGE_RD:   w = '{A_EDGE_RD_A, C_EDGE_BAD,  S_IDLE};
            S_EDGE_WA:   w = '{A_EDGE_WR_A, C_NEVER,     S_IDLE};
            S_EDGE_WB:   w = '{A_EDGE_WR_B, C_ALWAYS,    S_IDLE};
            S_WALK_INIT: w = '{A_INIT,      C_START_BAD, S_ZERO};
            S_WALK_ROOT: w = '{A_PUSH_ROOT, C_NEVER,     S_IDLE};
            S_ROW_RD:    w = '{A_RD_TOP,    C_NEVER,     S_IDLE};
            S_DECIDE:    w = '{A_STEP,      C_CAND,      S_ROW_RD};
            S_POP:       w = '{A_POP,       C_DEPTH_NZ,  S_ROW_RD};
            S_CHECK:     w = '{A_NOP,       C_ALL_LIT,   S_FLUSH};
            S_ZERO:      w = '{A_ZERO,      C_NEVER,     S_IDLE};
            S_FLUSH:     w = '{A_FLUSH,     C_ALWAYS,    S_IDLE};
            default:     w = '{A_NOP,       C_ALWAYS,    S_IDLE};
        endcase
        return w;
    endfunction

endpackage

### hdl/dfw_useq.sv
// ----------------------------------------------------------------------------
// dfw_useq
// Step counter and control store sequencer: issues one action per step and
// takes a conditional jump on the datapath flags.
// ----------------------------------------------------------------------------
module dfw_useq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  dfw_pkg::t_stat   i_stat,
    output dfw_pkg::t_act    o_act,
    output logic             o_busy
);

    dfw_pkg::t_step  r_pc;
    dfw_pkg::t_step  n_pc;
    dfw_pkg::t_uword uw;
    logic            take;

    // fetch the control word
    assign uw    = dfw_pkg::ucode(r_pc);
    assign o_act = uw.act;
    assign o_busy = (r_pc != dfw_pkg::S_IDLE);

    // jump condition
    always_comb begin
        case (uw.cond)
            dfw_pkg::C_NEVER:     take = 1'b0;
            dfw_pkg::C_ALWAYS:    take = 1'b1;
            dfw_pkg::C_NOSTART:   take = !i_start;
            dfw_pkg::C_WALK:      take = i_stat.walk;
            dfw_pkg::C_EDGE_BAD:  take = i_stat.edge_bad;
            dfw_pkg::C_START_BAD: take = i_stat.start_bad;
            dfw_pkg::C_CAND:      take = i_stat.cand;
            dfw_pkg::C_DEPTH_NZ:  take = i_stat.depth_nz;
            dfw_pkg::C_ALL_LIT:   take = i_stat.all_lit;
            default:              take = 1'b1;
        endcase
    end

    // next step
    always_comb begin
        if (take) begin
            n_pc = uw.target;
        end else begin
            n_pc = r_pc + dfw_pkg::t_step'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= dfw_pkg::S_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

### hdl/dfw_dpath.sv
// ----------------------------------------------------------------------------
// dfw_dpath
// Walk datapath: adjacency memory, lit marks, path stack, node count
// register and the one-deep hold of results so the final word is flagged.
// ----------------------------------------------------------------------------
module dfw_dpath #(
    parameter int MAX_NODES = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  dfw_pkg::t_cmd    i_cmd,
    input  logic             i_cfg_valid,
    input  dfw_pkg::t_node   i_cfg_data,
    input  dfw_pkg::t_act    i_act,
    output dfw_pkg::t_stat   o_stat,
    output logic             o_res_valid,
    output dfw_pkg::t_res    o_res
);

    localparam int IW = $clog2(MAX_NODES);
    localparam int DW = $clog2(MAX_NODES + 1);

    // storage
    logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
    logic [IW-1:0]        stk_mem [MAX_NODES];
    logic [MAX_NODES-1:0] r_row_vld;

    dfw_pkg::t_cmd        r_cmd;
    dfw_pkg::t_node       r_cfg;
    logic [MAX_NODES-1:0] r_row_q;
    logic                 r_row_qv;
    logic [IW-1:0]        r_stk_q;
    logic [MAX_NODES-1:0] r_lit, n_lit;
    logic [DW-1:0]        r_depth, n_depth;
    logic [IW-1:0]        r_top, n_top;
    dfw_pkg::t_node       r_pend, n_pend;
    logic                 r_pend_vld, n_pend_vld;
    dfw_pkg::t_res        r_res, n_res;
    logic                 r_res_vld, n_res_vld;

    dfw_pkg::t_node       eff_n;
    logic [MAX_NODES-1:0] mask;
    logic [MAX_NODES-1:0] row;
    logic [MAX_NODES-1:0] cand_vec;
    logic [MAX_NODES-1:0] bit_a, bit_b;
    logic [IW-1:0]        first;
    logic [IW-1:0]        a_idx, b_idx;
    logic                 a_ok, b_ok;
    logic                 cand_ok;
    logic [IW-1:0]        rd_addr;
    logic [IW-1:0]        stk_rd_addr;
    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    logic [MAX_NODES-1:0] wr_data;
    logic                 stk_wr;
    logic [IW-1:0]        stk_wr_addr;
    logic [IW-1:0]        stk_wr_data;
    logic                 prod;
    dfw_pkg::t_node       prod_val;
    logic                 flush;

    // node count clamped to the usable range
    always_comb begin
        if (r_cfg < dfw_pkg::t_node'(2)) begin
            eff_n = dfw_pkg::t_node'(2);
        end else if (r_cfg > dfw_pkg::t_node'(MAX_NODES)) begin
            eff_n = dfw_pkg::t_node'(MAX_NODES);
        end else begin
            eff_n = r_cfg;
        end
    end

    // in-use mask and one-hot endpoint bits
    always_comb begin
        for (int i = 0; i < MAX_NODES; i++) begin
            mask[i]  = (dfw_pkg::t_node'(i) < eff_n);
            bit_a[i] = (IW'(i) == a_idx);
            bit_b[i] = (IW'(i) == b_idx);
        end
    end

    assign a_idx = IW'(r_cmd.node_a - dfw_pkg::t_node'(1));
    assign b_idx = IW'(r_cmd.node_b - dfw_pkg::t_node'(1));
    assign a_ok  = (r_cmd.node_a != '0) && (r_cmd.node_a <= eff_n);
    assign b_ok  = (r_cmd.node_b != '0) && (r_cmd.node_b <= eff_n);

    // a row never written reads as empty
    assign row      = r_row_qv ? r_row_q : '0;
    assign cand_vec = row & ~r_lit & mask;
    assign cand_ok  = (|cand_vec) && (r_depth < DW'(MAX_NODES));

    // smallest unlit neighbour
    always_comb begin
        first = '0;
        for (int i = MAX_NODES - 1; i >= 0; i--) begin
            if (cand_vec[i]) begin
                first = IW'(i);
            end
        end
    end

    assign o_stat.walk      = (r_cmd.func == dfw_pkg::FUNC_WALK);
    assign o_stat.edge_bad  = !(a_ok && b_ok && (r_cmd.node_a != r_cmd.node_b));
    assign o_stat.start_bad = !a_ok;
    assign o_stat.cand      = cand_ok;
    assign o_stat.depth_nz  = (r_depth != '0);
    assign o_stat.all_lit   = ((r_lit & mask) == mask);

    // adjacency port control
    always_comb begin
        rd_addr = r_top;
        wr_en   = 1'b0;
        wr_addr = a_idx;
        wr_data = row | bit_b;
        case (i_act)
            dfw_pkg::A_EDGE_RD_A: begin
                rd_addr = a_idx;
            end
            dfw_pkg::A_EDGE_WR_A: begin
                rd_addr = b_idx;
                wr_en   = 1'b1;
            end
            dfw_pkg::A_EDGE_WR_B: begin
                wr_en   = 1'b1;
                wr_addr = b_idx;
                wr_data = row | bit_a;
            end
            default: begin
                rd_addr = r_top;
            end
        endcase
    end

    // walk control: stack, lit marks and result production
    always_comb begin
        n_lit       = r_lit;
        n_depth     = r_depth;
        n_top       = r_top;
        stk_wr      = 1'b0;
        stk_wr_addr = r_depth[IW-1:0];
        stk_wr_data = first;
        stk_rd_addr = IW'(r_depth - DW'(2));
        prod        = 1'b0;
        prod_val    = '0;
        flush       = 1'b0;
        case (i_act)
            dfw_pkg::A_INIT: begin
                n_lit   = '0;
                n_depth = '0;
            end
            dfw_pkg::A_PUSH_ROOT: begin
                n_lit       = r_lit | bit_a;
                n_depth     = DW'(1);
                n_top       = a_idx;
                stk_wr      = 1'b1;
                stk_wr_addr = '0;
                stk_wr_data = a_idx;
                prod        = 1'b1;
                prod_val    = r_cmd.node_a;
            end
            dfw_pkg::A_STEP: begin
                if (cand_ok) begin
                    n_lit    = r_lit | (MAX_NODES'(1) << first);
                    n_depth  = r_depth + DW'(1);
                    n_top    = first;
                    stk_wr   = 1'b1;
                    prod     = 1'b1;
                    prod_val = dfw_pkg::t_node'(first) + dfw_pkg::t_node'(1);
                end else begin
                    n_depth  = r_depth - DW'(1);
                end
            end
            dfw_pkg::A_POP: begin
                if (r_depth != '0) begin
                    n_top    = r_stk_q;
                    prod     = 1'b1;
                    prod_val = dfw_pkg::t_node'(r_stk_q) + dfw_pkg::t_node'(1);
                end
            end
            dfw_pkg::A_ZERO: begin
                prod     = 1'b1;
                prod_val = '0;
            end
            dfw_pkg::A_FLUSH: begin
                flush = 1'b1;
            end
            default: begin
                n_lit = r_lit;
            end
        endcase
    end

    // hold one result back so the final word can carry the last flag
    always_comb begin
        n_pend     = r_pend;
        n_pend_vld = r_pend_vld;
        n_res      = r_res;
        n_res_vld  = 1'b0;
        if (prod) begin
            n_pend     = prod_val;
            n_pend_vld = 1'b1;
            n_res      = '{node: r_pend, last: 1'b0};
            n_res_vld  = r_pend_vld;
        end else if (flush) begin
            n_pend_vld = 1'b0;
            n_res      = '{node: r_pend, last: 1'b1};
            n_res_vld  = r_pend_vld;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg      <= dfw_pkg::NODE_COUNT_RST;
            r_lit      <= '0;
            r_depth    <= '0;
            r_pend_vld <= 1'b0;
            r_res_vld  <= 1'b0;
            r_row_vld  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
            r_lit      <= n_lit;
            r_depth    <= n_depth;
            r_pend_vld <= n_pend_vld;
            r_res_vld  <= n_res_vld;
            if (wr_en) begin
                r_row_vld[wr_addr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_cmd <= i_cmd;
        end
        r_top  <= n_top;
        r_pend <= n_pend;
        r_res  <= n_res;
    end

    // adjacency memory, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            adj_mem[wr_addr] <= wr_data;
        end
        r_row_q  <= adj_mem[rd_addr];
        r_row_qv <= r_row_vld[rd_addr];
    end

    // path stack memory, registered read
    always_ff @(posedge i_clk) begin
        if (stk_wr) begin
            stk_mem[stk_wr_addr] <= stk_wr_data;
        end
        r_stk_q <= stk_mem[stk_rd_addr];
    end

    assign o_res_valid = r_res_vld;
    assign o_res       = r_res;

endmodule

### hdl/dfs_walk_with_backtrack.sv
// ----------------------------------------------------------------------------
// dfs_walk_with_backtrack
// Undirected graph walk engine: loads edges into an adjacency bit matrix and
// runs a depth-first walk, smallest unlit neighbour first, with backtracking.
// ----------------------------------------------------------------------------
//  channel   signals                          direction  handshake
//  command   start, busy, i_cmd               in         start & !busy
//  result    o_res_valid, o_res               out        strobe, one cycle
//  config    i_cfg_valid, o_cfg_ready, i_cfg_data  in    valid & ready
//
//  Edge word: sets the bit in both rows; an ignored edge (bad or equal endpoints) skips the writes.
//  Walk: a new node takes a row read and a decide step, a return a decide, a pop and a row
//  read (start node included); a zero word ends a walk that left a node unlit or had a bad start.
//  Reset clears the matrix (per-row valid bits), marks, depth and control.
//  A word is held until the next is made or the walk ends, then leaves from the result
//  register in the cycle after; the receiver cannot stall.
// ----------------------------------------------------------------------------
module dfs_walk_with_backtrack #(
    parameter int MAX_NODES = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  dfw_pkg::t_cmd    i_cmd,
    output logic             o_res_valid,
    output dfw_pkg::t_res    o_res,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  dfw_pkg::t_node   i_cfg_data
);

    dfw_pkg::t_stat stat;
    dfw_pkg::t_act  act;
    logic           accept;

    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;

    // sequencer
    dfw_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_act   (act),
        .o_busy  (busy)
    );

    // datapath
    dfw_dpath #(
        .MAX_NODES (MAX_NODES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_cmd       (i_cmd),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_act       (act),
        .o_stat      (stat),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

`ifndef NO_ASSERTIONS
    // an accepted word always starts the program
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted word did not start the sequencer");

    // results only come out of a running program
    a_res_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> $past(busy))
        else $error("result word without a running walk");

    // the flagged word coincides with the return to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.last) |-> !busy)
        else $error("last word while the sequencer is still running");
`endif

endmodule
